// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// RFP_ASSERT checks a property on every rising clock edge outside reset.
// RFP_NEVER checks that a condition is never true outside reset.
`ifndef SYNTH
`define RFP_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("assertion failed");
`define RFP_NEVER(lbl, ck, rn, expr) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) else $error("forbidden condition");
`else
`define RFP_ASSERT(lbl, ck, rn, prop)
`define RFP_NEVER(lbl, ck, rn, expr)
`endif

`endif

// ===== design/rfp_pkg.sv =====
`default_nettype none

package rfp_pkg;

	localparam int ORDER_W    = 7;
	localparam int START_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int IDX_BITS   = 12;
	localparam int VAL_BITS   = 64;

	typedef logic [ORDER_W-1:0] order_t;
	typedef logic [ORDER_W:0]   len_t;
	typedef logic [START_W-1:0] start_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORDER      = 2'd0,
		CFG_TRANSPOSED = 2'd1,
		CFG_LOWER      = 2'd2
	} cfg_reg_t;

	// Shape of one column of a loop nest: the number of columns in the nest,
	// the step between words of a column, the step between column starts,
	// the start of the first column and the length of the chosen column.
	typedef struct packed {
		order_t cnt;
		len_t   sd;
		len_t   delta;
		start_t start;
		len_t   len;
	} geom_t;

	function automatic geom_t walk_geom(input order_t n, input logic tr, input logic lo,
			input logic ph, input order_t o);
		order_t h;
		order_t r;
		logic   odd;
		len_t   lda;
		len_t   lda1;
		geom_t  g;
		h    = n >> 1;
		r    = n - h;
		odd  = n[0];
		lda  = tr ? len_t'(r) : (odd ? len_t'(n) : len_t'(n) + len_t'(1));
		lda1 = lda + len_t'(1);
		g.cnt = (lo != ph) ? r : h;
		unique case ({tr, lo, ph})
			3'b010: begin
				g.sd = len_t'(1); g.delta = lda1;
				g.start = odd ? start_t'(0) : start_t'(1);
				g.len = len_t'(n) - len_t'(o);
			end
			3'b011: begin
				g.sd = lda; g.delta = lda1;
				g.start = odd ? start_t'(lda) : start_t'(0);
				g.len = len_t'(h) - len_t'(o);
			end
			3'b000: begin
				g.sd = lda; g.delta = len_t'(1);
				g.start = start_t'(h) + start_t'(1);
				g.len = len_t'(o) + len_t'(1);
			end
			3'b001: begin
				g.sd = len_t'(1); g.delta = lda;
				g.start = start_t'(0);
				g.len = len_t'(h) + len_t'(o) + len_t'(1);
			end
			3'b110: begin
				g.sd = lda; g.delta = lda1;
				g.start = odd ? start_t'(0) : start_t'(lda);
				g.len = len_t'(n) - len_t'(o);
			end
			3'b111: begin
				g.sd = len_t'(1); g.delta = lda1;
				g.start = odd ? start_t'(1) : start_t'(0);
				g.len = len_t'(h) - len_t'(o);
			end
			3'b100: begin
				g.sd = len_t'(1); g.delta = lda;
				g.start = (start_t'(h) + start_t'(1)) * start_t'(lda);
				g.len = len_t'(o) + len_t'(1);
			end
			default: begin
				g.sd = lda; g.delta = len_t'(1);
				g.start = start_t'(0);
				g.len = len_t'(h) + len_t'(o) + len_t'(1);
			end
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

// ===== design/rfp_to_packed_reorder.sv =====
// Channel   Direction  Handshake           Beat
// config    in         cfg_we              cfg_index, cfg_data
// input     in         in_valid/in_stall   mode, rf_index, load_value
// result    out        out_valid/out_stall packed_index, out_value, last
//
// One input beat can be taken every cycle while in_stall is low. A read beat walks the
// index and reads the store into the stage behind the output register, then moves into
// the output register. The store has a single write port and a single registered read port.
// Reset clears the configuration and restarts the walk; store contents are undefined.
// A stalled result is held in the output register while one more read waits in the
// stage behind it; only when both are full is in_stall raised.
`default_nettype none

`include "assert_macros.svh"

module rfp_to_packed_reorder #(
	parameter int MAX_ORDER = 64,
	parameter int WORD_BITS = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [rfp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rfp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               mode,
	input  wire logic [rfp_pkg::IDX_BITS-1:0]       rf_index,
	input  wire logic [rfp_pkg::VAL_BITS-1:0]       load_value,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [rfp_pkg::IDX_BITS-1:0]            packed_index,
	output logic [rfp_pkg::VAL_BITS-1:0]            out_value,
	output logic                                    last
);

	localparam int RF_DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
	localparam int ADDR_W   = (RF_DEPTH > 1) ? $clog2(RF_DEPTH) : 1;
	localparam int IW       = $clog2(RF_DEPTH + 1);

	typedef logic [IW-1:0] idx_t;

	// Configuration.
	rfp_pkg::order_t order_q;
	logic            transposed_q;
	logic            lower_q;
	logic            cfg_hit;

	// Walk state. While fresh_q is set the walk sits at its start, worked out
	// from the present configuration.
	logic            fresh_q;
	logic            phase_q;
	rfp_pkg::order_t outer_q;
	rfp_pkg::order_t inner_q;
	idx_t            addr_q;
	idx_t            col_q;
	idx_t            pos_q;

	rfp_pkg::order_t n_eff;
	logic [15:0]     n_prod;
	logic [15:0]     n_total;
	rfp_pkg::geom_t  g_p0;
	rfp_pkg::geom_t  g_p1;
	rfp_pkg::geom_t  g_cur;
	logic            eph;
	rfp_pkg::order_t eouter;
	rfp_pkg::order_t einner;
	idx_t            eaddr;
	idx_t            ecol;
	idx_t            epos;
	idx_t            start_p1;
	logic            is_last;

	logic            nxt_fresh;
	logic            nxt_phase;
	rfp_pkg::order_t nxt_outer;
	rfp_pkg::order_t nxt_inner;
	idx_t            nxt_addr;
	idx_t            nxt_col;
	idx_t            col_step;

	logic            go;
	logic            emit_go;
	logic            load_go;
	logic            wr_ok;
	logic [31:0]     widx;
	logic [ADDR_W-1:0] ridx;

	logic [WORD_BITS-1:0] store_mem [RF_DEPTH];

	logic                 valid_s1;
	logic [WORD_BITS-1:0] data_s1;
	idx_t                 pos_s1;
	logic                 last_s1;
	logic                 move;

	logic                 out_valid_q;
	logic [WORD_BITS-1:0] data_q;
	idx_t                 pos_out_q;
	logic                 last_q;

	assign cfg_hit = cfg_we && (cfg_index == rfp_pkg::CFG_ORDER
		|| cfg_index == rfp_pkg::CFG_TRANSPOSED || cfg_index == rfp_pkg::CFG_LOWER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q      <= '0;
			transposed_q <= 1'b0;
			lower_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (rfp_pkg::cfg_reg_t'(cfg_index))
				rfp_pkg::CFG_ORDER:      order_q      <= cfg_data[rfp_pkg::ORDER_W-1:0];
				rfp_pkg::CFG_TRANSPOSED: transposed_q <= cfg_data[0];
				rfp_pkg::CFG_LOWER:      lower_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		n_eff   = (32'(order_q) > MAX_ORDER) ? rfp_pkg::order_t'(MAX_ORDER) : order_q;
		n_prod  = 16'(n_eff) * (16'(n_eff) + 16'd1);
		n_total = n_prod >> 1;

		g_p0 = rfp_pkg::walk_geom(n_eff, transposed_q, lower_q, 1'b0, '0);
		g_p1 = rfp_pkg::walk_geom(n_eff, transposed_q, lower_q, 1'b1, '0);
		start_p1 = idx_t'(g_p1.start);

		// An empty first nest (upper triangle of order one) starts in the second.
		eph    = fresh_q ? (g_p0.cnt == '0) : phase_q;
		eouter = fresh_q ? '0 : outer_q;
		einner = fresh_q ? '0 : inner_q;
		epos   = fresh_q ? '0 : pos_q;
		ecol   = fresh_q ? (eph ? start_p1 : idx_t'(g_p0.start)) : col_q;
		eaddr  = fresh_q ? ecol : addr_q;

		g_cur   = rfp_pkg::walk_geom(n_eff, transposed_q, lower_q, eph, eouter);
		is_last = (32'(epos) + 32'd1) >= 32'(n_total);
	end

	always_comb begin
		nxt_fresh = 1'b0;
		nxt_phase = eph;
		nxt_outer = eouter;
		nxt_inner = einner + rfp_pkg::order_t'(1);
		nxt_addr  = eaddr + idx_t'(g_cur.sd);
		nxt_col   = ecol;
		col_step  = ecol + idx_t'(g_cur.delta);
		if (is_last) begin
			nxt_fresh = 1'b1;
		end else if ((rfp_pkg::len_t'(einner) + rfp_pkg::len_t'(1)) >= g_cur.len) begin
			nxt_inner = '0;
			if ((rfp_pkg::len_t'(eouter) + rfp_pkg::len_t'(1)) < rfp_pkg::len_t'(g_cur.cnt)) begin
				nxt_outer = eouter + rfp_pkg::order_t'(1);
				nxt_col   = col_step;
				nxt_addr  = col_step;
			end else if (!eph && g_p1.cnt != '0) begin
				nxt_phase = 1'b1;
				nxt_outer = '0;
				nxt_col   = start_p1;
				nxt_addr  = start_p1;
			end else begin
				nxt_fresh = 1'b1;
			end
		end
	end

	assign move     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign go       = in_valid && !in_stall;
	assign emit_go  = go && mode && (n_eff != '0);
	assign load_go  = go && !mode;
	assign widx     = 32'(rf_index);
	assign wr_ok    = widx < RF_DEPTH;
	assign ridx     = ADDR_W'(eaddr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
			phase_q <= 1'b0;
			outer_q <= '0;
			inner_q <= '0;
			addr_q  <= '0;
			col_q   <= '0;
			pos_q   <= '0;
		end else if (cfg_hit) begin
			fresh_q <= 1'b1;
		end else if (emit_go) begin
			fresh_q <= nxt_fresh;
			phase_q <= nxt_phase;
			outer_q <= nxt_outer;
			inner_q <= nxt_inner;
			addr_q  <= nxt_addr;
			col_q   <= nxt_col;
			pos_q   <= epos + idx_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_go && wr_ok) begin
			store_mem[widx[ADDR_W-1:0]] <= load_value[WORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			data_s1 <= store_mem[ridx];
			pos_s1  <= epos;
			last_s1 <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= emit_go || (valid_s1 && !move);
			out_valid_q <= move || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			data_q    <= data_s1;
			pos_out_q <= pos_s1;
			last_q    <= last_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign packed_index = rfp_pkg::IDX_BITS'(pos_out_q);
	assign out_value    = rfp_pkg::VAL_BITS'(data_q);
	assign last         = last_q;

	`RFP_ASSERT(a_emit_fills_s1, clk, arst_n, emit_go |=> valid_s1)
	`RFP_NEVER(a_s1_not_lost, clk, arst_n, valid_s1 && !move && emit_go)
	`RFP_ASSERT(a_cfg_restarts, clk, arst_n, cfg_hit |=> fresh_q)
	`RFP_ASSERT(a_last_at_end, clk, arst_n, (valid_s1 && last_s1) |-> 32'(pos_s1) + 32'd1 == 32'(n_total))

endmodule

`default_nettype wire

// ===== test/rfp_to_packed_reorder_tb.sv =====
`timescale 1ns / 100ps

module rfp_to_packed_reorder_tb;

	localparam int MAX_N = 64;
	localparam int RF_DEPTH = MAX_N * (MAX_N + 1) / 2;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 250;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TARGET_ITEMS = 1950;
	localparam bit MODE_LOAD = 1'b0;
	localparam bit MODE_EMIT = 1'b1;
	localparam logic [rfp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [rfp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rfp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic [rfp_pkg::IDX_BITS-1:0] rf_index = '0;
	logic [rfp_pkg::VAL_BITS-1:0] load_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [rfp_pkg::IDX_BITS-1:0] packed_index;
	logic [rfp_pkg::VAL_BITS-1:0] out_value;
	logic last;

	bit gaps_on = 1'b1;
	bit hold_req = 1'b0;
	bit holding = 1'b0;
	int unsigned work_items = 0;
	int unsigned idle_cycles = 0;

	rfp_to_packed_reorder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.rf_index(rf_index),
		.load_value(load_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.packed_index(packed_index),
		.out_value(out_value),
		.last(last)
	);

	// Mirrors the RFP store and the readout walk, and holds the packed elements
	// still owed by the block.
	class rfp_readout_board;
		typedef struct {
			bit [11:0] pidx;
			bit [63:0] word;
			bit        fin;
		} elem_t;

		elem_t due_elems[$];
		bit [63:0] store [RF_DEPTH];
		bit written [RF_DEPTH];
		bit [6:0] order_r;
		bit tr_r;
		bit lo_r;
		int unsigned pos;
		bit phase;
		int unsigned outer;
		int unsigned inner;
		int unsigned base;
		int errors;

		function new();
			order_r = '0;
			tr_r = 1'b0;
			lo_r = 1'b0;
			errors = 0;
			restart_walk();
		endfunction

		function int unsigned eff_order();
			return (order_r > MAX_N) ? MAX_N : order_r;
		endfunction

		// Column o of loop nest ph: start, stride and length; returns the
		// number of columns in that nest.
		function int unsigned col_geom(bit ph, int unsigned o, output int unsigned st,
				output int unsigned sd, output int unsigned ln);
			int unsigned n, h, r, lda, cnt;
			bit odd;
			n = eff_order();
			h = n / 2;
			r = n - h;
			odd = n % 2;
			lda = tr_r ? r : (odd ? n : n + 1);
			if (!tr_r && lo_r) begin
				if (!ph) begin
					cnt = r; st = o * (lda + 1) + (odd ? 0 : 1); sd = 1; ln = n - o;
				end else begin
					cnt = h; st = o * (lda + 1) + (odd ? lda : 0); sd = lda; ln = h - o;
				end
			end else if (!tr_r) begin
				if (!ph) begin
					cnt = h; st = h + 1 + o; sd = lda; ln = o + 1;
				end else begin
					cnt = r; st = o * lda; sd = 1; ln = h + o + 1;
				end
			end else if (lo_r) begin
				if (!ph) begin
					cnt = r; st = o * (lda + 1) + (odd ? 0 : lda); sd = lda; ln = n - o;
				end else begin
					cnt = h; st = o * (lda + 1) + (odd ? 1 : 0); sd = 1; ln = h - o;
				end
			end else begin
				if (!ph) begin
					cnt = h; st = (h + 1 + o) * lda; sd = 1; ln = o + 1;
				end else begin
					cnt = r; st = o; sd = lda; ln = h + o + 1;
				end
			end
			return cnt;
		endfunction

		function void restart_walk();
			int unsigned st, sd, ln;
			pos = 0;
			phase = 1'b0;
			outer = 0;
			inner = 0;
			if (col_geom(1'b0, 0, st, sd, ln) == 0) begin
				phase = 1'b1;
				void'(col_geom(1'b1, 0, st, sd, ln));
			end
			base = st;
		endfunction

		function void step_walk();
			int unsigned st, sd, ln, cnt;
			cnt = col_geom(phase, outer, st, sd, ln);
			pos++;
			inner++;
			if (inner < ln)
				return;
			inner = 0;
			outer++;
			if (outer >= cnt) begin
				outer = 0;
				if (!phase && col_geom(1'b1, 0, st, sd, ln) != 0) begin
					phase = 1'b1;
				end else begin
					restart_walk();
					return;
				end
			end
			void'(col_geom(phase, outer, st, sd, ln));
			base = st;
		endfunction

		// Store entry that the next emit beat reads.
		function int unsigned read_addr();
			int unsigned st, sd, ln;
			void'(col_geom(phase, outer, st, sd, ln));
			return base + inner * sd;
		endfunction

		function void write_reg(bit [rfp_pkg::CFG_IDX_W-1:0] idx,
				bit [rfp_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				rfp_pkg::CFG_ORDER: order_r = data;
				rfp_pkg::CFG_TRANSPOSED: tr_r = data[0];
				rfp_pkg::CFG_LOWER: lo_r = data[0];
				default: return;
			endcase
			restart_walk();
		endfunction

		// Returns whether the beat did any work.
		function bit note_input(bit m, bit [11:0] idx, bit [63:0] word);
			int unsigned n, nt, a;
			elem_t e;
			if (m == MODE_LOAD) begin
				if (idx >= RF_DEPTH)
					return 1'b0;
				store[idx] = word;
				written[idx] = 1'b1;
				return 1'b1;
			end
			n = eff_order();
			if (n == 0)
				return 1'b0;
			nt = n * (n + 1) / 2;
			a = read_addr();
			e.pidx = pos[11:0];
			e.word = (a < RF_DEPTH) ? store[a] : '0;
			e.fin = (pos + 1 >= nt);
			due_elems.push_back(e);
			if (e.fin)
				restart_walk();
			else
				step_walk();
			return 1'b1;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("mismatch at %0t: %s", $time, msg);
		endfunction

		function void check_result(logic [11:0] pidx, logic [63:0] word, logic fin);
			elem_t e;
			if (due_elems.size() == 0) begin
				flag($sformatf("result with nothing due: index %0d value %h last %b",
					pidx, word, fin));
				return;
			end
			e = due_elems.pop_front();
			if (pidx !== e.pidx)
				flag($sformatf("packed_index expected %0d got %0d", e.pidx, pidx));
			if (word !== e.word)
				flag($sformatf("out_value at %0d expected %h got %h", e.pidx, e.word, word));
			if (fin !== e.fin)
				flag($sformatf("last at %0d expected %b got %b", e.pidx, e.fin, fin));
		endfunction

		function int pending();
			return due_elems.size();
		endfunction
	endclass

	rfp_readout_board sb = new();

	always #5 clk = ~clk;

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(packed_index, out_value, last);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: random stall runs, plus one long hold-off on request.
	initial begin
		int r;
		int run;
		bit s;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_req) begin
				holding = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				holding = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				s = (r >= 55);
				if (!s)
					run = $urandom_range(1, 30);
				else if (r < 92)
					run = $urandom_range(1, 3);
				else
					run = $urandom_range(10, 40);
				out_stall <= s;
				repeat (run) @(posedge clk);
			end
		end
	end

	function automatic bit [63:0] rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h7fff_ffff_ffff_ffff;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input bit m, input bit [11:0] idx, input bit [63:0] word);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		rf_index <= idx;
		load_value <= word;
		do @(posedge clk); while (in_stall);
		if (sb.note_input(m, idx, word))
			work_items++;
	endtask

	// An emit beat never reads a store entry that has not been loaded, so the
	// entry is loaded first where needed.
	task automatic emit_next();
		int unsigned a;
		if (sb.eff_order() != 0) begin
			a = sb.read_addr();
			if (!sb.written[a])
				send_item(MODE_LOAD, a[11:0], rand_word());
		end
		send_item(MODE_EMIT, 12'($urandom()), {$urandom(), $urandom()});
	endtask

	task automatic set_reg(input logic [rfp_pkg::CFG_IDX_W-1:0] idx,
			input logic [rfp_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic end_cfg();
		cfg_we <= 1'b0;
	endtask

	task automatic finish_phase();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase();
		int r;
		int unsigned n, nt, beats;
		bit [11:0] idx;
		r = $urandom_range(0, 99);
		if (r < 5)
			n = 0;
		else if (r < 9)
			n = $urandom_range(65, 127);
		else if (r < 17)
			n = $urandom_range(56, 64);
		else
			n = $urandom_range(1, 12);
		r = $urandom_range(1, 7);
		if (r[0])
			set_reg(rfp_pkg::CFG_ORDER, n[6:0]);
		if (r[1])
			set_reg(rfp_pkg::CFG_TRANSPOSED, 7'($urandom()));
		if (r[2])
			set_reg(rfp_pkg::CFG_LOWER, 7'($urandom()));
		if ($urandom_range(0, 9) == 0)
			set_reg(CFG_SPARE, 7'($urandom()));
		end_cfg();
		gaps_on = ($urandom_range(0, 3) != 0);
		n = sb.eff_order();
		nt = n * (n + 1) / 2;
		if (n == 0)
			beats = $urandom_range(1, 6);
		else if (n > 12)
			beats = $urandom_range(30, 120);
		else
			beats = $urandom_range(1, 2 * nt + 4);
		repeat (beats) begin
			if ($urandom_range(0, 99) < 30) begin
				r = $urandom_range(0, 99);
				if (r < 70 && nt != 0)
					idx = $urandom_range(0, nt - 1);
				else if (r < 85)
					idx = $urandom_range(0, RF_DEPTH - 1);
				else
					idx = $urandom_range(RF_DEPTH, 4095);
				send_item(MODE_LOAD, idx, rand_word());
			end else begin
				emit_next();
			end
		end
		finish_phase();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Order three, lower, normal layout: one full walk and the wrap.
		set_reg(rfp_pkg::CFG_ORDER, 7'd3);
		set_reg(rfp_pkg::CFG_TRANSPOSED, 7'd0);
		set_reg(rfp_pkg::CFG_LOWER, 7'd1);
		end_cfg();
		send_item(MODE_LOAD, 12'd0, 64'h0);
		send_item(MODE_LOAD, 12'd1, '1);
		send_item(MODE_LOAD, 12'd2, 64'h8000_0000_0000_0000);
		send_item(MODE_LOAD, 12'd3, 64'h0000_0000_0000_0001);
		send_item(MODE_LOAD, 12'd4, 64'h5555_5555_5555_5555);
		send_item(MODE_LOAD, 12'd5, 64'haaaa_aaaa_aaaa_aaaa);
		send_item(MODE_LOAD, 12'd4095, '1);
		send_item(MODE_LOAD, 12'd2079, rand_word());
		send_item(MODE_LOAD, 12'd2048, rand_word());
		repeat (7) emit_next();
		finish_phase();

		// An empty matrix gives nothing; order one gives entry zero each time.
		set_reg(rfp_pkg::CFG_ORDER, 7'd0);
		end_cfg();
		emit_next();
		finish_phase();
		set_reg(rfp_pkg::CFG_ORDER, 7'd1);
		end_cfg();
		repeat (2) emit_next();
		finish_phase();

		// Order beyond the largest is clamped; the spare register index does
		// not restart the walk.
		set_reg(rfp_pkg::CFG_ORDER, 7'd127);
		end_cfg();
		repeat (2) emit_next();
		finish_phase();
		set_reg(rfp_pkg::CFG_ORDER, 7'd64);
		set_reg(rfp_pkg::CFG_TRANSPOSED, 7'd1);
		end_cfg();
		repeat (2) emit_next();
		finish_phase();
		set_reg(CFG_SPARE, 7'd5);
		end_cfg();
		emit_next();
		finish_phase();

		// Long receiver hold-off with the sender streaming, so that the block
		// fills up and stalls its input.
		set_reg(rfp_pkg::CFG_ORDER, 7'd5);
		set_reg(rfp_pkg::CFG_TRANSPOSED, 7'd1);
		set_reg(rfp_pkg::CFG_LOWER, 7'd0);
		end_cfg();
		gaps_on = 1'b0;
		for (int i = 0; i < 15; i++)
			send_item(MODE_LOAD, i[11:0], rand_word());
		hold_req = 1'b1;
		wait (holding);
		repeat (30) emit_next();
		finish_phase();

		while (work_items < TARGET_ITEMS)
			run_phase();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
